// File: hw/rtl/lbbt_pkg.sv
// Shared types and constants of the label bounding box table.
package lbbt_pkg;

  localparam int unsigned COORD_W     = 10;
  localparam int unsigned LABEL_W     = 8;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [COORD_W-1:0] COORD_ONES = '1;
  localparam logic [LABEL_W-1:0] OBSTACLE_LABEL = 8'd0;
  localparam logic [LABEL_W-1:0] FREE_LABEL     = 8'd255;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef struct packed {
    logic [COORD_W-1:0] min_col;
    logic [COORD_W-1:0] max_col;
    logic [COORD_W-1:0] min_row;
    logic [COORD_W-1:0] max_row;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{
    min_col: COORD_ONES,
    max_col: '0,
    min_row: COORD_ONES,
    max_row: '0
  };

  typedef struct packed {
    logic               box_valid;
    logic [COORD_W-1:0] min_col;
    logic [COORD_W-1:0] max_col;
    logic [COORD_W-1:0] min_row;
    logic [COORD_W-1:0] max_row;
    logic [COORD_W-1:0] ctr_col;
    logic [COORD_W-1:0] ctr_row;
  } result_t;

  // write-back request from the update stage to the store
  typedef struct packed {
    logic               en;
    logic               set;   // 1: store data, 0: clear entry
    logic [LABEL_W-1:0] addr;
    entry_t             data;
  } wr_req_t;

endpackage

// File: hw/rtl/lbbt_store.sv
// Per-label box memory with valid bits and write-to-read forwarding.
module lbbt_store
  import lbbt_pkg::*;
#(
  parameter int unsigned LABEL_COUNT = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [LABEL_W-1:0] rd_addr_i,
  input  wr_req_t            wr_i,
  output entry_t             rd_data_o
);

  localparam int unsigned AW = $clog2(LABEL_COUNT);

  entry_t                 mem_q [LABEL_COUNT];
  logic [LABEL_COUNT-1:0] valid_q;
  entry_t                 rd_mem_q;
  logic                   rd_vld_q;
  logic                   fwd_q;
  entry_t                 wr_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.set) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_mem_q <= mem_q[rd_addr_i[AW-1:0]];
    end
    if (wr_i.en) begin
      wr_last_q <= wr_i.set ? wr_i.data : ENTRY_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr[AW-1:0]] <= wr_i.set;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i[AW-1:0]];
        // entry written on the same edge: memory returns stale data
        fwd_q    <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q    ? wr_last_q :
                     rd_vld_q ? rd_mem_q  : ENTRY_EMPTY;

endmodule

// File: hw/rtl/lbbt_calc.sv
// Box merge for pixel updates and result/centre computation for queries.
module lbbt_calc
  import lbbt_pkg::*;
(
  input  entry_t             entry_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  output entry_t             merged_o,
  output result_t            res_o
);

  logic               ok;
  logic [COORD_W-1:0] span_col;
  logic [COORD_W-1:0] span_row;

  always_comb begin
    merged_o.min_col = (col_i < entry_i.min_col) ? col_i : entry_i.min_col;
    merged_o.max_col = (col_i > entry_i.max_col) ? col_i : entry_i.max_col;
    merged_o.min_row = (row_i < entry_i.min_row) ? row_i : entry_i.min_row;
    merged_o.max_row = (row_i > entry_i.max_row) ? row_i : entry_i.max_row;
  end

  assign ok = (entry_i.max_col != '0) && (entry_i.max_row != '0) &&
              (entry_i.min_col <= entry_i.max_col) &&
              (entry_i.min_row <= entry_i.max_row);

  assign span_col = entry_i.max_col - entry_i.min_col;
  assign span_row = entry_i.max_row - entry_i.min_row;

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.box_valid = 1'b1;
      res_o.min_col   = entry_i.min_col;
      res_o.max_col   = entry_i.max_col;
      res_o.min_row   = entry_i.min_row;
      res_o.max_row   = entry_i.max_row;
      res_o.ctr_col   = entry_i.min_col + (span_col >> 1);
      res_o.ctr_row   = entry_i.min_row + (span_row >> 1);
    end
  end

endmodule

// File: hw/rtl/label_bounding_box_table.sv
// Top level of the label bounding box table.
//
// Slave stream: one transfer per item. tuser selects a pixel update or a
// query; tdata carries column, row, pixel label and query label. Pixels
// with label 0 or 255, labels outside the table or coordinates off the map
// are dropped. A query returns one master-stream transfer with the label's
// box and centre, then empties that entry.
// Throughput: one item per cycle, pixels and queries alike, unless stalled.
// The table sits in one memory whose read register loads together with a
// single read-modify-write stage; the entry written on the edge of a read
// is forwarded to that read. m_axis_tvalid comes from the result register.
// Reset: per-entry valid bits clear at once, so the table reads as empty
// straight after reset with no sweep.
// Stall: the result register holds until taken. Pixels keep flowing while
// it is full; a second query waits in the update stage and then the slave
// side deasserts tready.
module label_bounding_box_table
  import lbbt_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned LABEL_COUNT = 255
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // column[9:0], row[19:10], pix_label[27:20], query_label[35:28], zeros
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // req_type[0]
  input  logic [0:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // label_out[7:0], box_valid[8], min_column[18:9], max_column[28:19],
  // min_row[38:29], max_row[48:39], center_column[58:49],
  // center_row[68:59], zeros
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic [LABEL_W-1:0] in_pix;
  logic [LABEL_W-1:0] in_qry;
  logic               in_is_qry;
  logic               in_upd;
  logic               in_qok;
  logic               accept;
  logic [LABEL_W-1:0] rd_addr;

  logic               s1_valid_q;
  logic               s1_query_q;
  logic               s1_upd_q;
  logic               s1_qok_q;
  logic [LABEL_W-1:0] s1_label_q;
  logic [LABEL_W-1:0] s1_addr_q;
  logic [COORD_W-1:0] s1_col_q;
  logic [COORD_W-1:0] s1_row_q;
  logic               adv;

  entry_t             rd_entry;
  entry_t             merged;
  result_t            res;
  wr_req_t            wr;

  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  assign in_col    = s_axis_tdata_i[9:0];
  assign in_row    = s_axis_tdata_i[19:10];
  assign in_pix    = s_axis_tdata_i[27:20];
  assign in_qry    = s_axis_tdata_i[35:28];
  assign in_is_qry = (req_e'(s_axis_tuser_i[0]) == REQ_QUERY);

  assign in_upd = !in_is_qry && (in_pix != OBSTACLE_LABEL) && (in_pix != FREE_LABEL) &&
                  (32'(in_pix) < 32'(LABEL_COUNT)) &&
                  (32'(in_col) < 32'(MAX_COLUMNS)) && (32'(in_row) < 32'(MAX_ROWS));
  assign in_qok = in_is_qry && (32'(in_qry) < 32'(LABEL_COUNT));

  always_comb begin
    priority if (in_qok) begin
      rd_addr = in_qry;
    end else if (in_upd) begin
      rd_addr = in_pix;
    end else begin
      rd_addr = '0;
    end
  end

  assign adv    = s1_valid_q && (!s1_query_q || !m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || adv;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_query_q <= 1'b0;
      s1_upd_q   <= 1'b0;
      s1_qok_q   <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_query_q <= in_is_qry;
      s1_upd_q   <= in_upd;
      s1_qok_q   <= in_qok;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
      s1_upd_q   <= 1'b0;
      s1_qok_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_label_q <= in_qry;
      s1_addr_q  <= rd_addr;
      s1_col_q   <= in_col;
      s1_row_q   <= in_row;
    end
  end

  lbbt_store #(
    .LABEL_COUNT(LABEL_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(rd_addr),
    .wr_i     (wr),
    .rd_data_o(rd_entry)
  );

  lbbt_calc u_calc (
    .entry_i (rd_entry),
    .col_i   (s1_col_q),
    .row_i   (s1_row_q),
    .merged_o(merged),
    .res_o   (res)
  );

  always_comb begin
    wr.en   = adv && (s1_upd_q || s1_qok_q);
    wr.set  = s1_upd_q;
    wr.addr = s1_addr_q;
    wr.data = merged;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv && s1_query_q) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_query_q) begin
      m_data_q <= {3'b000, res.ctr_row, res.ctr_col, res.max_row, res.min_row,
                   res.max_col, res.min_col, s1_qok_q && res.box_valid, s1_label_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // backpressure only ever comes from a query waiting on a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && s1_query_q && m_valid_q))
    else $error("slave stalled without a blocked query");

  // write-back only from an occupied stage that is moving on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (s1_valid_q && adv))
    else $error("table write without a leaving item");

  // pixel updates never raise a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !s1_query_q && !m_valid_q) |=> !m_valid_q)
    else $error("result produced by a pixel update");

  // a query leaving the update stage always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_query_q) |=> m_valid_q)
    else $error("query result lost");
`endif

endmodule
